FILE: design/gbt_pkg.sv
// ---------------------------------------------------------------------------
// gbt_pkg: shared types and constants of the graph traversal engine
// Holds the command codes, the request descriptor that travels from the
// front end to the traversal engine, and the fixed field widths.
// ---------------------------------------------------------------------------
package gbt_pkg;

  // Fixed widths of the request and result fields.
  localparam int VTX_W     = 5;
  localparam int VC_W      = 6;
  localparam int CNT_W     = 7;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  // At most this many vertices are reported per traversal.
  localparam int OUT_MAX   = 32;
  localparam int OUT_CNT_W = 6;

  // Reset value of the vertex count register.
  localparam logic [VC_W-1:0] VC_RESET = 6'd32;

  // Register index of the vertex count register (address bit 2).
  localparam logic REG_VERTEX_COUNT = 1'b0;

  // Command codes of an input request.
  typedef enum logic [1:0] {
    CMD_EDGE = 2'd0,
    CMD_BFS  = 2'd1,
    CMD_DFS  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  // Work descriptor for the traversal engine. For a traversal, va holds
  // the start vertex; n is the effective vertex count at accept time.
  typedef struct packed {
    cmd_t             op;
    logic [VTX_W-1:0] va;
    logic [VTX_W-1:0] vb;
    logic [CNT_W-1:0] n;
  } desc_t;

endpackage

FILE: design/gbt_front.sv
// ---------------------------------------------------------------------------
// gbt_front: request intake and classification
// Owns the vertex count register, accepts requests, drops those that have
// no effect and forwards the rest as descriptors to the command queue.
// ---------------------------------------------------------------------------
module gbt_front #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_command,
  input  logic [gbt_pkg::VTX_W-1:0]       in_first_vertex,
  input  logic [gbt_pkg::VTX_W-1:0]       in_second_vertex,
  input  logic [gbt_pkg::VTX_W-1:0]       in_start_vertex,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gbt_pkg::APB_AW-1:0]      paddr,
  input  logic [gbt_pkg::APB_DW-1:0]      pwdata,
  output logic [gbt_pkg::APB_DW-1:0]      prdata,
  output logic                            pready,
  // Command queue side.
  input  logic                            q_full,
  output logic                            q_push,
  output gbt_pkg::desc_t                  q_desc
);

  localparam int CNT_W = gbt_pkg::CNT_W;
  localparam int APB_DW = gbt_pkg::APB_DW;
  localparam int VC_W = gbt_pkg::VC_W;
  localparam logic [CNT_W-1:0] MAXV = CNT_W'(MAX_VERTICES);

  logic [VC_W-1:0]  vc_r;
  logic [VC_W-1:0]  vc_nxt;
  logic             cfg_wr;
  logic [CNT_W-1:0] vc_ext;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] a_ext;
  logic [CNT_W-1:0] b_ext;
  logic [CNT_W-1:0] s_ext;
  gbt_pkg::cmd_t    cmd;
  logic             useful;

  // Register writes complete in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == gbt_pkg::REG_VERTEX_COUNT);
  assign vc_nxt = cfg_wr ? pwdata[VC_W-1:0] : vc_r;
  assign prdata = (paddr[2] == gbt_pkg::REG_VERTEX_COUNT) ? APB_DW'(vc_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= gbt_pkg::VC_RESET;
    end else begin
      vc_r <= vc_nxt;
    end
  end

  // The effective vertex count is limited by the matrix size.
  assign vc_ext = CNT_W'(vc_r);
  assign n_eff  = (vc_ext > MAXV) ? MAXV : vc_ext;
  assign a_ext  = CNT_W'(in_first_vertex);
  assign b_ext  = CNT_W'(in_second_vertex);
  assign s_ext  = CNT_W'(in_start_vertex);
  assign cmd    = gbt_pkg::cmd_t'(in_command);

  // Only in-range edges and in-range traversals reach the engine.
  always_comb begin
    case (cmd)
      gbt_pkg::CMD_EDGE: useful = (a_ext < n_eff) && (b_ext < n_eff);
      gbt_pkg::CMD_BFS:  useful = (s_ext < n_eff);
      gbt_pkg::CMD_DFS:  useful = (s_ext < n_eff);
      default:           useful = 1'b0;
    endcase
  end

  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full && useful;
  assign q_desc.op = cmd;
  assign q_desc.va = (cmd == gbt_pkg::CMD_EDGE) ? in_first_vertex : in_start_vertex;
  assign q_desc.vb = in_second_vertex;
  assign q_desc.n  = n_eff;

endmodule

FILE: design/gbt_cmd_fifo.sv
// ---------------------------------------------------------------------------
// gbt_cmd_fifo: two-entry command queue
// Decouples request intake from the traversal engine so that each side
// can stall on its own.
// ---------------------------------------------------------------------------
module gbt_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gbt_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output gbt_pkg::desc_t pop_desc
);

  gbt_pkg::desc_t entry_r [2];
  logic           wr_ptr_r;
  logic           wr_ptr_nxt;
  logic           rd_ptr_r;
  logic           rd_ptr_nxt;
  logic [1:0]     count_r;
  logic [1:0]     count_nxt;
  logic           do_push;
  logic           do_pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_desc  = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

FILE: design/gbt_back.sv
// ---------------------------------------------------------------------------
// gbt_back: traversal engine
// Executes edge inserts and breadth-first or depth-first walks over the
// adjacency memory, scanning one neighbor per cycle, and drives the
// result register.
// ---------------------------------------------------------------------------
module gbt_back #(
  parameter int MAX_VERTICES = 32,
  parameter int STACK_DEPTH  = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Command queue side.
  input  logic                      q_valid,
  input  gbt_pkg::desc_t            q_desc,
  output logic                      q_pop,
  // Result channel.
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [gbt_pkg::VTX_W-1:0] out_vertex_id,
  output logic                      out_last
);

  localparam int MV        = MAX_VERTICES;
  localparam int SD        = STACK_DEPTH;
  localparam int VW        = $clog2(MV);
  localparam int NW        = $clog2(MV + 1);
  localparam int SAW       = $clog2(SD);
  localparam int SPW       = $clog2(SD + 1);
  localparam int VTX_W     = gbt_pkg::VTX_W;
  localparam int OUT_CNT_W = gbt_pkg::OUT_CNT_W;
  localparam logic [MV-1:0]        ONE_BIT  = MV'(1);
  localparam logic [NW-1:0]        MV_N     = NW'(MV);
  localparam logic [SPW-1:0]       SD_N     = SPW'(SD);
  localparam logic [OUT_CNT_W-1:0] CNT_LAST = OUT_CNT_W'(gbt_pkg::OUT_MAX - 1);
  localparam logic [OUT_CNT_W-1:0] CNT_MAX  = OUT_CNT_W'(gbt_pkg::OUT_MAX);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_ERA   = 10'b00_0000_0010,
    S_EWA   = 10'b00_0000_0100,
    S_EWB   = 10'b00_0000_1000,
    S_INIT  = 10'b00_0001_0000,
    S_POP   = 10'b00_0010_0000,
    S_NODE  = 10'b00_0100_0000,
    S_LOAD  = 10'b00_1000_0000,
    S_SCAN  = 10'b01_0000_0000,
    S_FLUSH = 10'b10_0000_0000
  } bstate_t;

  // Control registers.
  bstate_t              state_r,    state_nxt;
  logic                 dfs_r,      dfs_nxt;
  logic [VW-1:0]        va_r,       va_nxt;
  logic [VW-1:0]        vb_r,       vb_nxt;
  logic [NW-1:0]        n_r,        n_nxt;
  logic [MV-1:0]        vis_r,      vis_nxt;
  logic [NW-1:0]        head_r,     head_nxt;
  logic [NW-1:0]        tail_r,     tail_nxt;
  logic [SPW-1:0]       sp_r,       sp_nxt;
  logic [NW-1:0]        j_r,        j_nxt;
  logic [MV-1:0]        row_r,      row_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  logic [VW-1:0]        pend_id_r,  pend_id_nxt;
  logic [OUT_CNT_W-1:0] cnt_r,      cnt_nxt;
  logic                 out_vld_r;
  logic [VTX_W-1:0]     out_id_r;
  logic                 out_last_r;

  // Memory ports.
  logic [MV-1:0] adj_mem [MV];
  logic [MV-1:0] adj_vld_r;
  logic [MV-1:0] adj_rdata_r;
  logic          adj_rvld_r;
  logic          adj_re;
  logic [VW-1:0] adj_raddr;
  logic          adj_we;
  logic [VW-1:0] adj_waddr;
  logic [MV-1:0] adj_wdata;
  logic [MV-1:0] adj_row;

  logic [VW-1:0] q_mem [MV];
  logic [VW-1:0] q_rdata_r;
  logic          q_re;
  logic [VW-1:0] q_raddr;
  logic          q_we;
  logic [VW-1:0] q_waddr;
  logic [VW-1:0] q_wdata;

  logic [VW-1:0] st_mem [SD];
  logic [VW-1:0] st_rdata_r;
  logic          st_re;
  logic [SAW-1:0] st_raddr;
  logic          st_we;
  logic [SAW-1:0] st_waddr;
  logic [VW-1:0] st_wdata;

  // Datapath helpers.
  logic           out_free;
  logic           emit_ok;
  logic           push_out;
  logic           push_last;
  logic [VW-1:0]  node;
  logic [VW-1:0]  jv;
  logic [SPW-1:0] sp_dec;

  assign out_free = !out_vld_r || !out_stall;
  assign emit_ok  = !pend_vld_r || out_free;
  assign adj_row  = adj_rvld_r ? adj_rdata_r : '0;
  assign node     = dfs_r ? st_rdata_r : q_rdata_r;
  assign jv       = j_r[VW-1:0];
  assign sp_dec   = sp_r - 1'b1;

  // Sequencer: edge insert, traversal setup, pop, emit, row scan, flush.
  always_comb begin
    state_nxt    = state_r;
    dfs_nxt      = dfs_r;
    va_nxt       = va_r;
    vb_nxt       = vb_r;
    n_nxt        = n_r;
    vis_nxt      = vis_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    sp_nxt       = sp_r;
    j_nxt        = j_r;
    row_nxt      = row_r;
    pend_vld_nxt = pend_vld_r;
    pend_id_nxt  = pend_id_r;
    cnt_nxt      = cnt_r;
    q_pop        = 1'b0;
    push_out     = 1'b0;
    push_last    = 1'b0;
    adj_re       = 1'b0;
    adj_raddr    = '0;
    adj_we       = 1'b0;
    adj_waddr    = '0;
    adj_wdata    = '0;
    q_re         = 1'b0;
    q_raddr      = '0;
    q_we         = 1'b0;
    q_waddr      = '0;
    q_wdata      = '0;
    st_re        = 1'b0;
    st_raddr     = '0;
    st_we        = 1'b0;
    st_waddr     = '0;
    st_wdata     = '0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          dfs_nxt = (q_desc.op == gbt_pkg::CMD_DFS);
          va_nxt  = VW'(q_desc.va);
          vb_nxt  = VW'(q_desc.vb);
          n_nxt   = NW'(q_desc.n);
          state_nxt = (q_desc.op == gbt_pkg::CMD_EDGE) ? S_ERA : S_INIT;
        end
      end
      S_ERA: begin
        adj_re    = 1'b1;
        adj_raddr = va_r;
        state_nxt = S_EWA;
      end
      S_EWA: begin
        // Set the first bit; a self edge has only this one.
        adj_we    = 1'b1;
        adj_waddr = va_r;
        adj_wdata = adj_row | (ONE_BIT << vb_r);
        if (va_r != vb_r) begin
          adj_re    = 1'b1;
          adj_raddr = vb_r;
          state_nxt = S_EWB;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EWB: begin
        adj_we    = 1'b1;
        adj_waddr = vb_r;
        adj_wdata = adj_row | (ONE_BIT << va_r);
        state_nxt = S_IDLE;
      end
      S_INIT: begin
        // Breadth-first marks on enqueue, depth-first on pop.
        vis_nxt      = dfs_r ? '0 : (ONE_BIT << va_r);
        cnt_nxt      = '0;
        pend_vld_nxt = 1'b0;
        head_nxt     = '0;
        if (dfs_r) begin
          st_we    = 1'b1;
          st_waddr = '0;
          st_wdata = va_r;
          sp_nxt   = SPW'(1);
        end else begin
          q_we     = 1'b1;
          q_waddr  = '0;
          q_wdata  = va_r;
          tail_nxt = NW'(1);
        end
        state_nxt = S_POP;
      end
      S_POP: begin
        if (dfs_r) begin
          if (sp_r == '0) begin
            state_nxt = S_FLUSH;
          end else begin
            st_re     = 1'b1;
            st_raddr  = sp_dec[SAW-1:0];
            sp_nxt    = sp_dec;
            state_nxt = S_NODE;
          end
        end else begin
          if (head_r == tail_r) begin
            state_nxt = S_FLUSH;
          end else begin
            q_re      = 1'b1;
            q_raddr   = head_r[VW-1:0];
            head_nxt  = head_r + 1'b1;
            state_nxt = S_NODE;
          end
        end
      end
      S_NODE: begin
        if (dfs_r && vis_r[node]) begin
          state_nxt = S_POP;
        end else if (emit_ok) begin
          // The previous vertex is known not to be last once a new one shows up.
          vis_nxt[node] = 1'b1;
          push_out      = pend_vld_r;
          pend_vld_nxt  = 1'b1;
          pend_id_nxt   = node;
          cnt_nxt       = cnt_r + 1'b1;
          adj_re        = 1'b1;
          adj_raddr     = node;
          state_nxt     = (cnt_r == CNT_LAST) ? S_FLUSH : S_LOAD;
        end
      end
      S_LOAD: begin
        row_nxt   = adj_row;
        j_nxt     = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (j_r == n_r) begin
          state_nxt = S_POP;
        end else begin
          if (row_r[jv] && !vis_r[jv]) begin
            if (dfs_r) begin
              if (sp_r < SD_N) begin
                st_we    = 1'b1;
                st_waddr = sp_r[SAW-1:0];
                st_wdata = jv;
                sp_nxt   = sp_r + 1'b1;
              end
            end else begin
              vis_nxt[jv] = 1'b1;
              if (tail_r < MV_N) begin
                q_we     = 1'b1;
                q_waddr  = tail_r[VW-1:0];
                q_wdata  = jv;
                tail_nxt = tail_r + 1'b1;
              end
            end
          end
          j_nxt = j_r + 1'b1;
        end
      end
      S_FLUSH: begin
        if (!pend_vld_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push_out     = 1'b1;
          push_last    = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      head_r     <= '0;
      tail_r     <= '0;
      sp_r       <= '0;
      cnt_r      <= '0;
      j_r        <= '0;
      n_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      pend_vld_r <= pend_vld_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      sp_r       <= sp_nxt;
      cnt_r      <= cnt_nxt;
      j_r        <= j_nxt;
      n_r        <= n_nxt;
      if (push_out) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    dfs_r     <= dfs_nxt;
    va_r      <= va_nxt;
    vb_r      <= vb_nxt;
    vis_r     <= vis_nxt;
    row_r     <= row_nxt;
    pend_id_r <= pend_id_nxt;
    if (push_out) begin
      out_id_r   <= VTX_W'(pend_id_r);
      out_last_r <= push_last;
    end
  end

  // Adjacency memory; rows never written read as empty.
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (adj_re) begin
      adj_rdata_r <= adj_mem[adj_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_vld_r  <= '0;
      adj_rvld_r <= 1'b0;
    end else begin
      if (adj_we) begin
        adj_vld_r[adj_waddr] <= 1'b1;
      end
      if (adj_re) begin
        adj_rvld_r <= adj_vld_r[adj_raddr];
      end
    end
  end

  // Frontier queue memory.
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rdata_r <= q_mem[q_raddr];
    end
  end

  // Pending stack memory.
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata_r <= st_mem[st_raddr];
    end
  end

  assign out_valid     = out_vld_r;
  assign out_vertex_id = out_id_r;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  // A traversal always holds its final vertex when it reaches the flush.
  a_flush_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH) |-> pend_vld_r)
    else $error("flush without a pending vertex");

  // Queue and stack pointers stay inside their storage.
  a_pointer_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (sp_r <= SD_N) && (tail_r <= MV_N) && (head_r <= tail_r))
    else $error("queue or stack pointer out of range");

  // No more results than the per-traversal limit.
  a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("result count above limit");

  // The row scan never runs past the vertex count.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (j_r <= n_r))
    else $error("row scan index past vertex count");
`endif

endmodule

FILE: design/graph_bfs_dfs_traversal.sv
// ---------------------------------------------------------------------------
// graph_bfs_dfs_traversal: graph traversal engine over an adjacency matrix
// Keeps an undirected adjacency matrix and runs breadth-first or
// depth-first walks, reporting visited vertices in visit order.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_ channel (valid/stall). Command 0 adds an
//   undirected edge, 1 runs a breadth-first and 2 a depth-first walk from
//   in_start_vertex. Out-of-range edges and starts, and command 3, are
//   accepted and dropped. Each walk returns one result per visited vertex
//   on the out_ channel, at most 32, with out_last on the final one.
//   The vertex count register lies at address 0 of the APB port; the user
//   must write it only while the block is idle (not enforced by the block).
// Operation:
//   An edge insert runs through the engine states S_ERA, S_EWA and S_EWB
//   (S_EWB is skipped for a self edge). A walk pops a vertex, emits it, loads
//   its row and scans it one neighbor per cycle up to the vertex count.
//   A two-entry command queue lets requests be accepted while a walk runs.
// Reset:
//   Reset clears the matrix (per-row valid bits, no clearing pass) and
//   sets the vertex count to 32. A stalled result holds the engine until
//   it is taken; the request side stalls only when the queue is full.
// ---------------------------------------------------------------------------
module graph_bfs_dfs_traversal #(
  parameter int MAX_VERTICES = 32,
  parameter int STACK_DEPTH  = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Request channel.
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_command,
  input  logic [gbt_pkg::VTX_W-1:0]  in_first_vertex,
  input  logic [gbt_pkg::VTX_W-1:0]  in_second_vertex,
  input  logic [gbt_pkg::VTX_W-1:0]  in_start_vertex,
  // Result channel.
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [gbt_pkg::VTX_W-1:0]  out_vertex_id,
  output logic                       out_last,
  // Configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gbt_pkg::APB_AW-1:0] paddr,
  input  logic [gbt_pkg::APB_DW-1:0] pwdata,
  output logic [gbt_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  logic           q_full;
  logic           q_push;
  gbt_pkg::desc_t q_push_desc;
  logic           q_pop;
  logic           q_valid;
  gbt_pkg::desc_t q_pop_desc;

  // Request intake and register port.
  gbt_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_first_vertex  (in_first_vertex),
    .in_second_vertex (in_second_vertex),
    .in_start_vertex  (in_start_vertex),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_desc           (q_push_desc)
  );

  // Command queue between intake and engine.
  gbt_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_desc  (q_pop_desc)
  );

  // Traversal engine and result register.
  gbt_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_desc        (q_pop_desc),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_vertex_id (out_vertex_id),
    .out_last      (out_last)
  );

endmodule
